### rtl/core/ksld_pkg.sv
// shared types and constants for the keypad scan serial led display
package ksld_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CODES_W = 64;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] PERIOD_LIMIT_RESET = 16'd120;
    localparam logic [CODES_W-1:0] KEY_CODES_RESET = 64'hDF0E_C987_B654_A321;

    // blanking counts 1..5, then wraps to zero (not blanking)
    localparam logic [2:0] BLANK_FIRST = 3'd1;
    localparam logic [2:0] BLANK_LAST = 3'd5;
    localparam logic [2:0] BLANK_OFF = 3'd0;
    localparam logic [1:0] LAST_BIT = 2'd3;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_COLUMN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_LIMIT = 2'd0,
        CFG_KEY_CODES    = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0] tick_count;
        logic [1:0]         scan_row;
        logic [1:0]         last_column;
        logic [3:0]         shown_code;
        logic               showing;
        logic [1:0]         bit_position;
        logic [2:0]         blank_phase;
        logic               red_level;
        logic               green_level;
    } disp_state_t;

endpackage

### rtl/core/ksld_cfg.sv
// configuration register file: period limit and key code table
module ksld_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [ksld_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ksld_pkg::CODES_W-1:0]      wr_data,
    output logic [ksld_pkg::COUNT_W-1:0]      period_limit,
    output logic [ksld_pkg::CODES_W-1:0]      key_codes
);

    logic [ksld_pkg::COUNT_W-1:0] period_limit_reg;
    logic [ksld_pkg::COUNT_W-1:0] period_limit_next;
    logic [ksld_pkg::CODES_W-1:0] key_codes_reg;
    logic [ksld_pkg::CODES_W-1:0] key_codes_next;

    always_comb
    begin
        period_limit_next = period_limit_reg;
        key_codes_next = key_codes_reg;
        if (wr_en)
        begin
            case (ksld_pkg::cfg_index_t'(wr_index))
                ksld_pkg::CFG_PERIOD_LIMIT:
                    period_limit_next = wr_data[ksld_pkg::COUNT_W-1:0];
                ksld_pkg::CFG_KEY_CODES:
                    key_codes_next = wr_data;
                default:
                    ; // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_limit_reg <= ksld_pkg::PERIOD_LIMIT_RESET;
            key_codes_reg <= ksld_pkg::KEY_CODES_RESET;
        end
        else
        begin
            period_limit_reg <= period_limit_next;
            key_codes_reg <= key_codes_next;
        end
    end

    assign period_limit = period_limit_reg;
    assign key_codes = key_codes_reg;

endmodule

### rtl/core/ksld_step.sv
// next-state logic for one tick or column request
module ksld_step (
    input  ksld_pkg::disp_state_t            cur,
    input  logic                             mode,
    input  logic [3:0]                       column_flags,
    input  logic [ksld_pkg::COUNT_W-1:0]     period_limit,
    input  logic [ksld_pkg::CODES_W-1:0]     key_codes,
    output ksld_pkg::disp_state_t            nxt
);

    logic [ksld_pkg::COUNT_W-1:0] count_inc;
    logic [1:0]                   column;
    logic [3:0]                   nib_idx;
    logic                         red_toggled;

    always_comb
    begin
        nxt = cur;
        count_inc = cur.tick_count + 1'b1;
        red_toggled = ~cur.red_level;
        column = cur.last_column;
        case (column_flags)
            4'b0001: column = 2'd0;
            4'b0010: column = 2'd1;
            4'b0100: column = 2'd2;
            4'b1000: column = 2'd3;
            default: column = cur.last_column;
        endcase
        nib_idx = {cur.scan_row, column};

        if (mode == ksld_pkg::MODE_TICK)
        begin
            nxt.scan_row = cur.scan_row + 2'd1;
            nxt.tick_count = count_inc;
            if (count_inc > period_limit)
            begin
                nxt.tick_count = '0;
                if (cur.blank_phase != ksld_pkg::BLANK_OFF)
                begin
                    nxt.red_level = 1'b0;
                    nxt.green_level = 1'b0;
                    nxt.blank_phase = (cur.blank_phase == ksld_pkg::BLANK_LAST)
                                    ? ksld_pkg::BLANK_OFF
                                    : cur.blank_phase + 3'd1;
                end
                else
                begin
                    nxt.red_level = red_toggled;
                    // data bit follows the rising edge of the clock led
                    if (red_toggled && cur.showing)
                    begin
                        nxt.green_level = cur.shown_code[cur.bit_position];
                        if (cur.bit_position == ksld_pkg::LAST_BIT)
                        begin
                            nxt.shown_code = '0;
                            nxt.showing = 1'b0;
                            nxt.bit_position = '0;
                            nxt.blank_phase = ksld_pkg::BLANK_FIRST;
                        end
                        else
                        begin
                            nxt.bit_position = cur.bit_position + 2'd1;
                        end
                    end
                end
            end
        end
        else if (!cur.showing)
        begin
            nxt.last_column = column;
            nxt.shown_code = key_codes[{nib_idx, 2'b00} +: 4];
            nxt.showing = 1'b1;
            nxt.blank_phase = ksld_pkg::BLANK_FIRST;
        end
    end

endmodule

### rtl/core/keypad_scan_serial_led_display.sv
// top level: input register, state update, result register
//
// Keypad row scanner with a two-led serial display of the captured key code.
// Input channel (in_valid/in_ready): mode 0 is a timer tick that steps the
// row scan and the period divider, mode 1 is a column request carrying the
// one-hot column_flags. Every request gives exactly one result on the output
// channel (out_valid/out_ready): the row now driven and both led levels.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 sets
// period_limit (low 16 bits of cfg_data), index 1 sets the 64-bit key code
// table; other indexes are ignored. Write only while no request is in flight.
// Each request waits in the input register, then the state update loads the
// result register.
// Throughput is one request per cycle while the receiver takes the results.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are occupied.
// Reset clears all display state, loads period_limit 120 and the default key
// table, and empties both stages.
module keypad_scan_serial_led_display (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [3:0]                        column_flags,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        row_drive,
    output logic                              red_led,
    output logic                              data_led,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ksld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ksld_pkg::CODES_W-1:0]      cfg_data
);

    logic                            s1_valid_reg;
    logic                            s1_mode_reg;
    logic [3:0]                      s1_flags_reg;
    logic                            out_valid_reg;
    logic [1:0]                      row_drive_reg;
    logic                            red_led_reg;
    logic                            data_led_reg;
    ksld_pkg::disp_state_t           state_reg;
    ksld_pkg::disp_state_t           state_next;
    logic [ksld_pkg::COUNT_W-1:0]    period_limit;
    logic [ksld_pkg::CODES_W-1:0]    key_codes;
    logic                            advance;

    assign cfg_ready = 1'b1;
    assign advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    ksld_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (cfg_valid && cfg_ready),
        .wr_index     (cfg_index),
        .wr_data      (cfg_data),
        .period_limit (period_limit),
        .key_codes    (key_codes)
    );

    ksld_step u_step (
        .cur          (state_reg),
        .mode         (s1_mode_reg),
        .column_flags (s1_flags_reg),
        .period_limit (period_limit),
        .key_codes    (key_codes),
        .nxt          (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg <= mode;
            s1_flags_reg <= column_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            out_valid_reg <= 1'b0;
            row_drive_reg <= '0;
            red_led_reg <= 1'b0;
            data_led_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            out_valid_reg <= 1'b1;
            row_drive_reg <= state_next.scan_row;
            red_led_reg <= state_next.red_level;
            data_led_reg <= state_next.green_level;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_drive = row_drive_reg;
    assign red_led = red_led_reg;
    assign data_led = data_led_reg;

    // result register always mirrors the committed state
    assert property (@(posedge clk) disable iff (!rst_n)
        row_drive_reg == state_reg.scan_row && red_led_reg == state_reg.red_level
        && data_led_reg == state_reg.green_level)
        else $error("result register out of step with state");

    // idle display carries no leftover code or bit position
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.showing |-> state_reg.bit_position == 2'd0
        && state_reg.shown_code == 4'd0)
        else $error("idle display holds stale code");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.blank_phase <= ksld_pkg::BLANK_LAST)
        else $error("blank phase out of range");

    // a tick always steps the row scan
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_mode_reg == ksld_pkg::MODE_TICK
        |=> state_reg.scan_row == $past(state_reg.scan_row) + 2'd1)
        else $error("tick did not step row scan");

    // a stalled result never gets overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule

### sim/keypad_scan_serial_led_display_tb.sv
// testbench for the keypad scan serial led display: directed and random requests, predicted leds
module keypad_scan_serial_led_display_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;
    // indexes with no register behind them
    localparam logic [ksld_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [ksld_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [1:0] row;
        logic       red;
        logic       data;
    } led_view_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           mode = ksld_pkg::MODE_TICK;
    logic [3:0]                     column_flags = 4'd0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [1:0]                     row_drive;
    logic                           red_led;
    logic                           data_led;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ksld_pkg::CFG_IDX_W-1:0] cfg_index = ksld_pkg::CFG_PERIOD_LIMIT;
    logic [ksld_pkg::CODES_W-1:0]   cfg_data = '0;

    // predictor copy of the block
    ksld_pkg::disp_state_t          disp;
    logic [ksld_pkg::COUNT_W-1:0]   model_limit;
    logic [ksld_pkg::CODES_W-1:0]   model_codes;

    led_view_t            pending_leds[$];
    int                   errors = 0;
    int unsigned          cycle = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_left = 0;

    keypad_scan_serial_led_display u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .column_flags (column_flags),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_drive    (row_drive),
        .red_led      (red_led),
        .data_led     (data_led),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        led_view_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_leds.size() == 0)
            begin
                $error("result with no request waiting: row_drive %0d red_led %0d data_led %0d",
                       row_drive, red_led, data_led);
                errors++;
            end
            else
            begin
                want = pending_leds.pop_front();
                if (row_drive !== want.row)
                begin
                    $error("row_drive expected %0d actual %0d", want.row, row_drive);
                    errors++;
                end
                if (red_led !== want.red)
                begin
                    $error("red_led expected %0d actual %0d", want.red, red_led);
                    errors++;
                end
                if (data_led !== want.data)
                begin
                    $error("data_led expected %0d actual %0d", want.data, data_led);
                    errors++;
                end
            end
        end
    end

    function automatic led_view_t advance_display(input logic m, input logic [3:0] flags);
        led_view_t  res;
        logic [3:0] idx;
        if (m == ksld_pkg::MODE_TICK)
        begin
            disp.tick_count = disp.tick_count + 1'b1;
            if (disp.tick_count > model_limit)
            begin
                disp.tick_count = '0;
                if (disp.blank_phase != ksld_pkg::BLANK_OFF)
                begin
                    disp.red_level = 1'b0;
                    disp.green_level = 1'b0;
                    disp.blank_phase = (disp.blank_phase == ksld_pkg::BLANK_LAST)
                                     ? ksld_pkg::BLANK_OFF
                                     : disp.blank_phase + 1'b1;
                end
                else
                begin
                    disp.red_level = ~disp.red_level;
                    // while a code is on show, the next code bit goes out on each rising edge of the clock led
                    if (disp.red_level && disp.showing)
                    begin
                        disp.green_level = disp.shown_code[disp.bit_position];
                        if (disp.bit_position == ksld_pkg::LAST_BIT)
                        begin
                            disp.shown_code = '0;
                            disp.showing = 1'b0;
                            disp.bit_position = '0;
                            disp.blank_phase = ksld_pkg::BLANK_FIRST;
                        end
                        else
                        begin
                            disp.bit_position = disp.bit_position + 1'b1;
                        end
                    end
                end
            end
            disp.scan_row = disp.scan_row + 1'b1;
        end
        else if (!disp.showing)
        begin
            case (flags)
                4'b0001: disp.last_column = 2'd0;
                4'b0010: disp.last_column = 2'd1;
                4'b0100: disp.last_column = 2'd2;
                4'b1000: disp.last_column = 2'd3;
                default: ;
            endcase
            idx = {disp.scan_row, disp.last_column};
            disp.shown_code = model_codes[idx*4 +: 4];
            disp.showing = 1'b1;
            disp.blank_phase = ksld_pkg::BLANK_FIRST;
        end
        res.row = disp.scan_row;
        res.red = disp.red_level;
        res.data = disp.green_level;
        return res;
    endfunction

    task automatic send_item(input logic m, input logic [3:0] flags);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        column_flags = flags;
        do
            @(posedge clk);
        while (!in_ready);
        pending_leds.push_back(advance_display(m, flags));
    endtask

    task automatic write_reg(input logic [ksld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ksld_pkg::CODES_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == ksld_pkg::CFG_PERIOD_LIMIT)
            model_limit = data[ksld_pkg::COUNT_W-1:0];
        else if (idx == ksld_pkg::CFG_KEY_CODES)
            model_codes = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop offering requests and wait for every result
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_leds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n, input bit pause_midway);
        logic       m;
        logic [3:0] flags;
        for (int i = 0; i < n; i++)
        begin
            m = ($urandom_range(99) < 15) ? ksld_pkg::MODE_COLUMN : ksld_pkg::MODE_TICK;
            if (m == ksld_pkg::MODE_COLUMN && $urandom_range(3) != 0)
                flags = 4'b0001 << $urandom_range(3);
            else
                flags = 4'($urandom_range(15));
            send_item(m, flags);
            if (pause_midway && i == n / 2)
                wait_drain();
        end
    endtask

    task automatic test_reset_defaults();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(ksld_pkg::MODE_TICK, 4'hF);
        send_item(ksld_pkg::MODE_COLUMN, 4'b0100);
        // ignored while a code is on show
        send_item(ksld_pkg::MODE_COLUMN, 4'b0001);
        wait_drain();
    endtask

    task automatic test_show_sequence();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd0);
        write_reg(ksld_pkg::CFG_KEY_CODES, {ksld_pkg::CODES_W{1'b1}});
        send_item(ksld_pkg::MODE_COLUMN, 4'b1000);
        repeat (12) send_item(ksld_pkg::MODE_TICK, 4'h0);
        // idle but blanking: no flags keeps the column, restarts blanking
        send_item(ksld_pkg::MODE_COLUMN, 4'b0000);
        send_item(ksld_pkg::MODE_COLUMN, 4'b1111);
        send_item(ksld_pkg::MODE_TICK, 4'hA);
        wait_drain();
    endtask

    task automatic test_limit_extremes();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, {ksld_pkg::CODES_W{1'b1}});
        write_reg(CFG_SPARE_2, 64'd0);
        write_reg(CFG_SPARE_3, {$urandom, $urandom});
        repeat (3) send_item(ksld_pkg::MODE_TICK, 4'h5);
        wait_drain();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd1);
        repeat (3) send_item(ksld_pkg::MODE_TICK, 4'h0);
        wait_drain();
    endtask

    task automatic test_random_no_idle();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd0);
        write_reg(ksld_pkg::CFG_KEY_CODES, {$urandom, $urandom});
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(400, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_sender_idle();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd1);
        write_reg(ksld_pkg::CFG_KEY_CODES, {$urandom, $urandom});
        send_idle_pct = 76;
        recv_stall_pct = 0;
        run_random(400, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_receiver_stall();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd2);
        write_reg(ksld_pkg::CFG_KEY_CODES, 64'd0);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        run_random(400, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_both_idle();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd3);
        write_reg(ksld_pkg::CFG_KEY_CODES, {$urandom, $urandom});
        send_idle_pct = 34;
        recv_stall_pct = 34;
        run_random(400, 1'b1);
        wait_drain();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'($urandom_range(4, 9)));
        run_random(150, 1'b0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_left = 200;
        run_random(40, 1'b0);
        wait_drain();
    endtask

    task automatic test_large_limit();
        write_reg(ksld_pkg::CFG_PERIOD_LIMIT, 64'd65534);
        write_reg(ksld_pkg::CFG_KEY_CODES, {$urandom, $urandom});
        send_idle_pct = 34;
        recv_stall_pct = 34;
        run_random(100, 1'b0);
        wait_drain();
    endtask

    initial
    begin
        disp = '0;
        model_limit = ksld_pkg::PERIOD_LIMIT_RESET;
        model_codes = ksld_pkg::KEY_CODES_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_show_sequence();
        test_limit_extremes();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();
        test_large_limit();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
